[src/ppssa_pkg.sv]
package ppssa_pkg;

   localparam int TIME_BITS = 48;
   localparam int COUNT_BITS_DEF = 16;
   localparam int TIME_FRAC_BITS_DEF = 32;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   localparam logic [31:0] PREY_BIRTH_RESET = 32'd1966080;
   localparam logic [31:0] PREDATION_RESET = 32'd6554;
   localparam logic [31:0] PRED_DEATH_RESET = 32'd1966080;
   localparam logic [15:0] INIT_PREY_RESET = 16'd80;
   localparam logic [15:0] INIT_PRED_RESET = 16'd20;
   localparam logic [TIME_BITS-1:0] TIME_LIMIT_RESET = 48'd214748364800;

   typedef logic [2:0] event_type;
   localparam event_type EV_RESTART = 3'd0;
   localparam event_type EV_BIRTH = 3'd1;
   localparam event_type EV_PREDATION = 3'd2;
   localparam event_type EV_DEATH = 3'd3;
   localparam event_type EV_ENDED = 3'd4;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type REG_PREY_BIRTH = 3'd0;
   localparam csr_index_type REG_PREDATION = 3'd1;
   localparam csr_index_type REG_PRED_DEATH = 3'd2;
   localparam csr_index_type REG_INIT_PREY = 3'd3;
   localparam csr_index_type REG_INIT_PRED = 3'd4;
   localparam csr_index_type REG_TIME_LIMIT = 3'd5;

   localparam logic CMD_RESTART = 1'b0;

endpackage

[src/predator_prey_ssa_step.sv]
// Channel | Direction | tdata (low bit up)                                  | tuser
// req     | in        | rand_time[31:0], rand_select[31:0]                  | cmd
// rsp     | out       | sim_time[47:0], prey, predators, running, saturated | event_res
// csr     | in        | csr_index[2:0], csr_wdata[47:0]                     | -
//
// A step uses five products on the shared 32x32 multiplier for the rates, a normalise
// phase when rand_time[31] is clear, 32 squarings for the log, the restoring
// divider, then selection. Restart and not-running steps go from idle straight to
// the result state; a step with zero total rate ends after the total-rate state.
// Reset is synchronous and loads the default registers and the initial state.
// req_tready is high only while idle; a result held on rsp stalls the next finish.
module predator_prey_ssa_step #(
   parameter int COUNT_BITS = ppssa_pkg::COUNT_BITS_DEF,
   parameter int TIME_FRAC_BITS = ppssa_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // rand_time, rand_select
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // sim_time, prey_count, predator_count, running, saturated
   output logic [2:0]  rsp_tuser,   // event_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int TB = ppssa_pkg::TIME_BITS;
   localparam int DIV_SHIFT = TIME_FRAC_BITS - 16;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RB   = 5'd1;
   localparam logic [4:0] S_P1   = 5'd2;
   localparam logic [4:0] S_P2   = 5'd3;
   localparam logic [4:0] S_P3   = 5'd4;
   localparam logic [4:0] S_RD   = 5'd5;
   localparam logic [4:0] S_TOT  = 5'd6;
   localparam logic [4:0] S_NORM = 5'd7;
   localparam logic [4:0] S_SQ   = 5'd8;
   localparam logic [4:0] S_L1   = 5'd9;
   localparam logic [4:0] S_L2   = 5'd10;
   localparam logic [4:0] S_DIV  = 5'd11;
   localparam logic [4:0] S_SS1  = 5'd12;
   localparam logic [4:0] S_SS2  = 5'd13;
   localparam logic [4:0] S_SS3  = 5'd14;
   localparam logic [4:0] S_SEL  = 5'd15;
   localparam logic [4:0] S_DONE = 5'd16;

   logic [31:0] birth_ff, predn_ff, death_ff;
   logic [15:0] init_prey_ff, init_pred_ff;
   logic [TB-1:0] limit_ff;

   logic [4:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [TB-1:0] time_ff, time_in;
   logic [COUNT_BITS-1:0] prey_ff, prey_in, pred_ff, pred_in;
   logic [31:0] rt_ff, rt_in, rs_ff, rs_in;
   logic [63:0] rb_ff, rb_in, pp_ff, pp_in, rp_ff, rp_in, rd_ff, rd_in, tot_ff, tot_in;
   logic [31:0] m_ff, m_in, f_ff, f_in;
   logic [5:0] ip_ff, ip_in;
   logic [39:0] nl_ff, nl_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [95:0] full_ff, full_in;
   logic [63:0] ra_ff, ra_in;
   logic [2:0] ev_ff, ev_in;
   logic sat_ff, sat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [87:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_user_ff, rsp_user_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [31:0] prey32, pred32;
   logic [64:0] sum65;
   logic [63:0] tot_sum;
   logic [37:0] lval;
   logic [39:0] nl_sum;
   logic [64:0] rem_sh;
   logic [96:0] s97;
   logic [64:0] nt65;
   logic [63:0] ra_rest;
   logic running_now;

   assign prey32 = 32'(prey_ff);
   assign pred32 = 32'(pred_ff);
   assign running_now = (prey_ff != '0) && (pred_ff != '0) && (time_ff < limit_ff);
   assign lval = {ip_ff, 32'b0} - {6'b0, f_ff};

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_RB: begin mul_a = birth_ff; mul_b = prey32; end
         S_P1: begin mul_a = predn_ff; mul_b = prey32; end
         S_P2: begin mul_a = pp_ff[31:0]; mul_b = pred32; end
         S_P3: begin mul_a = pp_ff[63:32]; mul_b = pred32; end
         S_RD: begin mul_a = death_ff; mul_b = pred32; end
         S_SQ: begin mul_a = m_ff; mul_b = m_ff; end
         S_L1: begin mul_a = {26'b0, lval[37:32]}; mul_b = ppssa_pkg::LN2_Q32; end
         S_L2: begin mul_a = lval[31:0]; mul_b = ppssa_pkg::LN2_Q32; end
         S_SS1: begin mul_a = rs_ff; mul_b = tot_ff[31:0]; end
         S_SS2: begin mul_a = rs_ff; mul_b = tot_ff[63:32]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign sum65 = {1'b0, tot_ff} + {1'b0, rd_ff};
   assign tot_sum = sum65[64] ? '1 : sum65[63:0];
   assign nl_sum = nl_ff + {8'b0, mul_p[63:32]};
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign s97 = {full_ff, 1'b0} + {33'b0, tot_ff};
   assign nt65 = 65'(time_ff) + {1'b0, quo_ff};
   assign ra_rest = ra_ff - rb_ff;

   always_comb begin
      logic [64:0] s;
      state_in = state_ff;
      cnt_in = cnt_ff;
      time_in = time_ff;
      prey_in = prey_ff;
      pred_in = pred_ff;
      rt_in = rt_ff;
      rs_in = rs_ff;
      rb_in = rb_ff;
      pp_in = pp_ff;
      rp_in = rp_ff;
      rd_in = rd_ff;
      tot_in = tot_ff;
      m_in = m_ff;
      f_in = f_ff;
      ip_in = ip_ff;
      nl_in = nl_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      full_in = full_ff;
      ra_in = ra_ff;
      ev_in = ev_ff;
      sat_in = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      s = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rt_in = req_tdata[31:0];
               rs_in = req_tdata[63:32];
               sat_in = 1'b0;
               if (req_tuser == ppssa_pkg::CMD_RESTART) begin
                  prey_in = COUNT_BITS'(init_prey_ff);
                  pred_in = COUNT_BITS'(init_pred_ff);
                  time_in = '0;
                  ev_in = ppssa_pkg::EV_RESTART;
                  state_in = S_DONE;
               end else if (!running_now) begin
                  ev_in = ppssa_pkg::EV_ENDED;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RB;
               end
            end
         end
         S_RB: begin rb_in = mul_p; state_in = S_P1; end
         S_P1: begin pp_in = mul_p; state_in = S_P2; end
         S_P2: begin rp_in = mul_p; state_in = S_P3; end
         S_P3: begin
            s = {1'b0, mul_p[31:0], 32'b0} + {1'b0, rp_ff};
            rp_in = (mul_p[63:32] != '0 || s[64]) ? '1 : s[63:0];
            state_in = S_RD;
         end
         S_RD: begin
            rd_in = mul_p;
            s = {1'b0, rb_ff} + {1'b0, rp_ff};
            tot_in = s[64] ? '1 : s[63:0];
            state_in = S_TOT;
         end
         S_TOT: begin
            tot_in = tot_sum;
            if (tot_sum == '0) begin
               time_in = ppssa_pkg::TIME_MAX;
               ev_in = ppssa_pkg::EV_ENDED;
               state_in = S_DONE;
            end else if (rt_ff[31]) begin
               m_in = {1'b1, rt_ff[30:0]};
               ip_in = 6'd1;
               cnt_in = '0;
               state_in = S_SQ;
            end else begin
               m_in = {rt_ff[30:0], 1'b1};
               ip_in = 6'd2;
               cnt_in = 6'd4;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            case (cnt_ff[2:0])
               3'd4: if (m_ff[31:16] == '0) begin
                  m_in = {m_ff[15:0], 16'b0}; ip_in = ip_ff + 6'd16;
               end
               3'd3: if (m_ff[31:24] == '0) begin
                  m_in = {m_ff[23:0], 8'b0}; ip_in = ip_ff + 6'd8;
               end
               3'd2: if (m_ff[31:28] == '0) begin
                  m_in = {m_ff[27:0], 4'b0}; ip_in = ip_ff + 6'd4;
               end
               3'd1: if (m_ff[31:30] == '0) begin
                  m_in = {m_ff[29:0], 2'b0}; ip_in = ip_ff + 6'd2;
               end
               default: if (!m_ff[31]) begin
                  m_in = {m_ff[30:0], 1'b0}; ip_in = ip_ff + 6'd1;
               end
            endcase
            if (cnt_ff == '0) begin
               state_in = S_SQ;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_SQ: begin
            f_in = {f_ff[30:0], mul_p[63]};
            m_in = mul_p[63] ? mul_p[63:32] : mul_p[62:31];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in = '0;
               state_in = S_L1;
            end
         end
         S_L1: begin nl_in = mul_p[39:0]; state_in = S_L2; end
         S_L2: begin
            nl_in = nl_sum;
            quo_in = 64'(nl_sum) << DIV_SHIFT;
            rem_in = '0;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, tot_ff}) begin
               rem_in = rem_sh[63:0] - tot_ff;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_SS1;
         end
         S_SS1: begin full_in = {32'b0, mul_p}; state_in = S_SS2; end
         S_SS2: begin full_in = full_ff + {mul_p, 32'b0}; state_in = S_SS3; end
         S_SS3: begin ra_in = s97[96:33]; state_in = S_SEL; end
         S_SEL: begin
            time_in = (nt65 > 65'(ppssa_pkg::TIME_MAX)) ? ppssa_pkg::TIME_MAX : nt65[TB-1:0];
            if (ra_ff < rb_ff) begin
               ev_in = ppssa_pkg::EV_BIRTH;
               if (prey_ff == '1) sat_in = 1'b1;
               else prey_in = prey_ff + COUNT_BITS'(1);
            end else if (ra_rest < rp_ff) begin
               ev_in = ppssa_pkg::EV_PREDATION;
               prey_in = prey_ff - COUNT_BITS'(1);
               if (pred_ff == '1) sat_in = 1'b1;
               else pred_in = pred_ff + COUNT_BITS'(1);
            end else begin
               ev_in = ppssa_pkg::EV_DEATH;
               pred_in = pred_ff - COUNT_BITS'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'b0, sat_ff, running_now, pred32[15:0], prey32[15:0], time_ff};
               rsp_user_in = ev_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         time_ff <= '0;
         prey_ff <= COUNT_BITS'(ppssa_pkg::INIT_PREY_RESET);
         pred_ff <= COUNT_BITS'(ppssa_pkg::INIT_PRED_RESET);
         rsp_valid_ff <= 1'b0;
         ev_ff <= ppssa_pkg::EV_RESTART;
         sat_ff <= 1'b0;
         birth_ff <= ppssa_pkg::PREY_BIRTH_RESET;
         predn_ff <= ppssa_pkg::PREDATION_RESET;
         death_ff <= ppssa_pkg::PRED_DEATH_RESET;
         init_prey_ff <= ppssa_pkg::INIT_PREY_RESET;
         init_pred_ff <= ppssa_pkg::INIT_PRED_RESET;
         limit_ff <= ppssa_pkg::TIME_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         time_ff <= time_in;
         prey_ff <= prey_in;
         pred_ff <= pred_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_ff <= ev_in;
         sat_ff <= sat_in;
         if (csr_valid) begin
            case (csr_index)
               ppssa_pkg::REG_PREY_BIRTH: birth_ff <= csr_wdata[31:0];
               ppssa_pkg::REG_PREDATION:  predn_ff <= csr_wdata[31:0];
               ppssa_pkg::REG_PRED_DEATH: death_ff <= csr_wdata[31:0];
               ppssa_pkg::REG_INIT_PREY:  init_prey_ff <= csr_wdata[15:0];
               ppssa_pkg::REG_INIT_PRED:  init_pred_ff <= csr_wdata[15:0];
               ppssa_pkg::REG_TIME_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rt_ff <= rt_in;
      rs_ff <= rs_in;
      rb_ff <= rb_in;
      pp_ff <= pp_in;
      rp_ff <= rp_in;
      rd_ff <= rd_in;
      tot_ff <= tot_in;
      m_ff <= m_in;
      f_ff <= f_in;
      ip_ff <= ip_in;
      nl_ff <= nl_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      full_ff <= full_in;
      ra_ff <= ra_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

`ifndef SYNTHESIS
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ppssa_pkg::EV_RESTART |->
         rsp_tdata[47:0] == '0 && !rsp_tdata[81])
      else $error("restart result with nonzero time or saturation");
   a_ended_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ppssa_pkg::EV_ENDED |-> !rsp_tdata[80] && !rsp_tdata[81])
      else $error("ended result reports running or saturation");
   a_running_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[80] |-> rsp_tdata[63:48] != '0 || COUNT_BITS > 16)
      else $error("running with no prey");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |=> !req_tready)
      else $error("accepting while dividing");
`endif

endmodule

[sim/predator_prey_ssa_step_tb.sv]
module predator_prey_ssa_step_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [47:0] sim_time;
      logic [15:0] prey;
      logic [15:0] predators;
      ppssa_pkg::event_type ev;
      logic        running;
      logic        saturated;
   } population_type;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // predictor copy of registers and state
   logic [31:0] birth_rate, predation_rate, death_rate;
   logic [15:0] start_prey, start_predators;
   logic [47:0] limit_time;
   logic [47:0] now_time;
   logic [15:0] now_prey, now_predators;

   population_type pending_states[$];
   int          mismatches = 0;
   int          stall_request = 0;
   bit          no_idle = 1'b0;

   predator_prey_ssa_step dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("FAIL predator_prey_ssa_step");
      $finish;
   end

   function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] pr;
      pr = {64'b0, a} * {64'b0, b};
      return (pr[127:64] != 0) ? '1 : pr[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] neg_log_q32(logic [31:0] r);
      logic [63:0] x, m, f, sq, l2;
      int p;
      x = {31'b0, r, 1'b1};
      p = 0;
      for (int i = 0; i < 34; i++) if (x[i]) p = i;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      f = '0;
      for (int i = 0; i < 32; i++) begin
         sq = m * m;
         f = f << 1;
         if (sq[63]) begin
            f[0] = 1'b1;
            m = sq >> 32;
         end else begin
            m = sq >> 31;
         end
      end
      l2 = (64'(33 - p) << 32) - f;
      return (l2 >> 32) * 64'(ppssa_pkg::LN2_Q32) +
             (((l2 & 64'hFFFF_FFFF) * 64'(ppssa_pkg::LN2_Q32)) >> 32);
   endfunction

   function automatic logic [63:0] select_point(logic [31:0] r, logic [63:0] t);
      logic [127:0] v;
      v = {95'b0, r, 1'b1} * {64'b0, t};
      return 64'(v >> 33);
   endfunction

   function automatic bit is_running();
      return now_prey != 0 && now_predators != 0 && now_time < limit_time;
   endfunction

   function automatic population_type advance_population(logic cmd, logic [31:0] rt,
                                                         logic [31:0] rs);
      population_type o;
      logic [63:0] ra_b, ra_p, ra_d, tot, dt, ra;
      logic [64:0] nt;
      o.ev = ppssa_pkg::EV_ENDED;
      o.saturated = 1'b0;
      if (cmd == ppssa_pkg::CMD_RESTART) begin
         now_prey = start_prey;
         now_predators = start_predators;
         now_time = '0;
         o.ev = ppssa_pkg::EV_RESTART;
      end else if (is_running()) begin
         ra_b = mul_sat(64'(birth_rate), 64'(now_prey));
         ra_p = mul_sat(mul_sat(64'(predation_rate), 64'(now_prey)), 64'(now_predators));
         ra_d = mul_sat(64'(death_rate), 64'(now_predators));
         tot = add_sat(add_sat(ra_b, ra_p), ra_d);
         if (tot == 0) begin
            now_time = ppssa_pkg::TIME_MAX;
         end else begin
            dt = (neg_log_q32(rt) << 16) / tot;
            ra = select_point(rs, tot);
            nt = {17'b0, now_time} + {1'b0, dt};
            now_time = (nt > {17'b0, ppssa_pkg::TIME_MAX}) ? ppssa_pkg::TIME_MAX : nt[47:0];
            if (ra < ra_b) begin
               o.ev = ppssa_pkg::EV_BIRTH;
               if (now_prey == COUNT_MAX) o.saturated = 1'b1;
               else now_prey++;
            end else if (ra - ra_b < ra_p) begin
               o.ev = ppssa_pkg::EV_PREDATION;
               now_prey--;
               if (now_predators == COUNT_MAX) o.saturated = 1'b1;
               else now_predators++;
            end else begin
               o.ev = ppssa_pkg::EV_DEATH;
               now_predators--;
            end
         end
      end
      o.sim_time = now_time;
      o.prey = now_prey;
      o.predators = now_predators;
      o.running = is_running();
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // result side: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      int stall_left;
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_idle || reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(20, 120);
         rsp_tready <= ($urandom_range(0, 99) < 75);
      end
   end

   always @(posedge clock) begin
      population_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: %h/%h",
                                           rsp_tdata, rsp_tuser);
         end else begin
            e = pending_states.pop_front();
            if (rsp_tdata[47:0] !== e.sim_time || rsp_tdata[63:48] !== e.prey ||
                rsp_tdata[79:64] !== e.predators || rsp_tdata[80] !== e.running ||
                rsp_tdata[81] !== e.saturated || rsp_tuser !== e.ev) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp t=%h prey=%0d pred=%0d ev=%0d run=%b sat=%b",
                           e.sim_time, e.prey, e.predators, e.ev, e.running, e.saturated,
                           " got t=%h prey=%0d pred=%0d ev=%0d run=%b sat=%b",
                           rsp_tdata[47:0], rsp_tdata[63:48], rsp_tdata[79:64],
                           rsp_tuser, rsp_tdata[80], rsp_tdata[81]);
            end
         end
      end
   end

   task automatic send_item(logic cmd, logic [31:0] rt, logic [31:0] rs);
      int n;
      @(negedge clock);
      n = pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {rs, rt};
      do @(posedge clock); while (!req_tready);
      pending_states.push_back(advance_population(cmd, rt, rs));
   endtask

   task automatic step_item();
      send_item(1'b1, $urandom, $urandom);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(ppssa_pkg::csr_index_type idx, logic [47:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ppssa_pkg::REG_PREY_BIRTH: birth_rate = value[31:0];
         ppssa_pkg::REG_PREDATION:  predation_rate = value[31:0];
         ppssa_pkg::REG_PRED_DEATH: death_rate = value[31:0];
         ppssa_pkg::REG_INIT_PREY:  start_prey = value[15:0];
         ppssa_pkg::REG_INIT_PRED:  start_predators = value[15:0];
         ppssa_pkg::REG_TIME_LIMIT: limit_time = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_model(logic [31:0] b, logic [31:0] p, logic [31:0] d,
                            logic [15:0] np, logic [15:0] nd, logic [47:0] lim);
      wait_idle();
      write_csr(ppssa_pkg::REG_PREY_BIRTH, {16'hA5A5, b});
      write_csr(ppssa_pkg::REG_PREDATION, {16'h5A5A, p});
      write_csr(ppssa_pkg::REG_PRED_DEATH, {16'($urandom_range(0, 65535)), d});
      write_csr(ppssa_pkg::REG_INIT_PREY, {16'($urandom), 16'($urandom), np});
      write_csr(ppssa_pkg::REG_INIT_PRED, {16'($urandom), 16'($urandom), nd});
      write_csr(ppssa_pkg::REG_TIME_LIMIT, lim);
   endtask

   task automatic test_defaults();
      step_item();
      send_item(1'b1, 32'h0, 32'h0);
      send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b1, 32'h0, 32'hFFFF_FFFF);
      send_item(ppssa_pkg::CMD_RESTART, 32'hFFFF_FFFF, 32'h0);
      step_item();
   endtask

   task automatic test_saturation();
      set_model('1, 0, 0, COUNT_MAX, 16'd1, ppssa_pkg::TIME_MAX);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      repeat (2) step_item();
      set_model(0, 32'h0001_0000, 0, 16'd100, COUNT_MAX, ppssa_pkg::TIME_MAX);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      repeat (2) step_item();
   endtask

   task automatic test_zero_rate_and_limits();
      set_model(0, 0, 0, 16'd10, 16'd10, ppssa_pkg::TIME_MAX);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      repeat (2) step_item();
      set_model(32'h0001_0000, 6554, 32'h0001_0000, 16'd10, 16'd10, 48'd0);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      step_item();
      set_model(32'h0001_0000, 6554, 32'h0001_0000, 16'd10, 16'd10, 48'd1);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      repeat (2) step_item();
      set_model(32'h0001_0000, 6554, 32'h0001_0000, 16'd0, 16'd10, ppssa_pkg::TIME_MAX);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      step_item();
   endtask

   task automatic test_extremes();
      set_model('1, '1, '1, COUNT_MAX, COUNT_MAX, ppssa_pkg::TIME_MAX);
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      repeat (3) step_item();
   endtask

   task automatic test_backpressure();
      set_model(ppssa_pkg::PREY_BIRTH_RESET, ppssa_pkg::PREDATION_RESET,
                ppssa_pkg::PRED_DEATH_RESET, ppssa_pkg::INIT_PREY_RESET,
                ppssa_pkg::INIT_PRED_RESET, ppssa_pkg::TIME_LIMIT_RESET);
      no_idle = 1'b1;
      send_item(ppssa_pkg::CMD_RESTART, 0, 0);
      stall_request = 1500;
      repeat (12) step_item();
      repeat (30) step_item();
      no_idle = 1'b0;
   endtask

   function automatic logic [31:0] pick_rate();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return '1;
      if (r == 2) return $urandom;
      return $urandom_range(0, 40 << 16);
   endfunction

   function automatic logic [15:0] pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return COUNT_MAX;
      if (r == 1) return 16'($urandom);
      return 16'($urandom_range(0, 120));
   endfunction

   function automatic logic [47:0] pick_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return ppssa_pkg::TIME_MAX;
      if (r == 1) return 48'({$urandom, $urandom});
      return {14'b0, 2'($urandom), $urandom};
   endfunction

   task automatic test_random();
      int sent;
      int run;
      sent = 0;
      while (sent < 1850) begin
         set_model(pick_rate(), (($urandom_range(0, 3) == 0) ? pick_rate() :
                   32'($urandom_range(0, 1 << 15))), pick_rate(), pick_count(),
                   pick_count(), pick_limit());
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 6)) begin
            send_item(ppssa_pkg::CMD_RESTART, $urandom, $urandom);
            run = $urandom_range(1, 60);
            repeat (run) begin
               if ($urandom_range(0, 49) == 0)
                  send_item(ppssa_pkg::CMD_RESTART, $urandom, $urandom);
               else step_item();
            end
            sent += run + 1;
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      birth_rate = ppssa_pkg::PREY_BIRTH_RESET;
      predation_rate = ppssa_pkg::PREDATION_RESET;
      death_rate = ppssa_pkg::PRED_DEATH_RESET;
      start_prey = ppssa_pkg::INIT_PREY_RESET;
      start_predators = ppssa_pkg::INIT_PRED_RESET;
      limit_time = ppssa_pkg::TIME_LIMIT_RESET;
      now_time = '0;
      now_prey = ppssa_pkg::INIT_PREY_RESET;
      now_predators = ppssa_pkg::INIT_PRED_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_saturation();
      test_zero_rate_and_limits();
      test_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS predator_prey_ssa_step");
      end else begin
         $display("FAIL predator_prey_ssa_step");
      end
      $finish;
   end

endmodule

[sim.f]
src/ppssa_pkg.sv
src/predator_prey_ssa_step.sv
sim/predator_prey_ssa_step_tb.sv
